// ===== hdl/cpcd_pkg.sv =====
// Shared constants, types and helpers for the clock page cache directory.
`timescale 1ns / 1ps
package cpcd_pkg;

  localparam int FRAMES      = 256;
  localparam int FRAME_BITS  = 8;
  localparam int SLOTS       = 512;
  localparam int SLOT_BITS   = 9;
  localparam int DEPTH_BITS  = 9;   // holds 0..FRAMES
  localparam int SWEEP_BITS  = 10;  // holds 0..2*FRAMES
  localparam int PAGE_BITS   = 64;
  localparam int SLOT_WIDTH  = PAGE_BITS + FRAME_BITS;
  localparam logic [63:0] HASH_MUL = 64'd11400714819323198485;

  typedef enum logic [1:0] {
    FN_LOOKUP   = 2'd0,
    FN_INSERT   = 2'd1,
    FN_REMOVE   = 2'd2,
    FN_RESERVED = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_LOC, ST_POP, ST_SWEEP, ST_VRD,
    ST_ER, ST_ERC, ST_ALLOC, ST_PLC, ST_OUT
  } state_t;

  // Home slot: only the low slot bits of the product matter.
  function automatic logic [SLOT_BITS-1:0] home_of(input logic [PAGE_BITS-1:0] pid);
    logic [2*SLOT_BITS-1:0] p;
    p = pid[SLOT_BITS-1:0] * HASH_MUL[SLOT_BITS-1:0];
    return p[SLOT_BITS-1:0];
  endfunction

endpackage

// ===== hdl/cpcd_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module cpcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/clock_page_cache_directory_unit.sv =====
// Page cache directory: one result per request, one request at a time. After reset a clearing
// pass empties the slot table and the frame status before the first request is taken. A remove
// then fills the freed slot by a backward shift. An insert miss probes twice (lookup, then
// placement) and, when no frame is free, adds the CLOCK sweep (one frame per cycle) and the
// victim's lookup and shift.
`timescale 1ns / 1ps
module clock_page_cache_directory_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,  // func[1:0], page_id[65:2], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata   // rejected[0], hit[1], frame[9:2], evicted[10],
                                // evicted_page[74:11], zero fill
);
  import cpcd_pkg::*;

  state_t state, state_next;
  logic [SLOT_BITS-1:0]  s, s_next, cnt, cnt_next, hole, hole_next, j, j_next;
  logic [SLOT_BITS-1:0]  n, n_next, outer, outer_next, clr, clr_next;
  logic [PAGE_BITS-1:0]  tgt, tgt_next, pid, pid_next;
  logic [1:0]            op, op_next;
  logic                  ev, ev_next, stk_wr, stk_wr_next, vvalid, vvalid_next;
  logic [FRAME_BITS-1:0] fsel, fsel_next, hand, hand_next;
  logic [DEPTH_BITS-1:0] depth, depth_next, lowmark, lowmark_next;
  logic [SWEEP_BITS-1:0] swn, swn_next;
  logic                  res_rej, res_rej_next, res_hit, res_hit_next;
  logic                  res_ev, res_ev_next;
  logic [FRAME_BITS-1:0] res_frame, res_frame_next;
  logic [PAGE_BITS-1:0]  res_evp, res_evp_next;
  logic                  load;

  // slot table
  logic                  sl_we;
  logic [SLOT_BITS-1:0]  sl_waddr, sl_raddr;
  logic [SLOT_WIDTH-1:0] sl_wdata, sl_rdata;
  logic [PAGE_BITS-1:0]  sd_page;
  logic [FRAME_BITS-1:0] sd_frame;
  logic [SLOT_BITS-1:0]  sd_home;
  logic                  stays;
  // frame pages and free stack
  logic                  fp_we, st_we;
  logic [FRAME_BITS-1:0] fp_waddr, fp_raddr, st_waddr, st_raddr, st_wdata, st_rdata;
  logic [PAGE_BITS-1:0]  fp_wdata, fp_rdata;
  logic [DEPTH_BITS-1:0] depth_m1;
  // frame status: bit 0 valid, bit 1 reference
  logic                  fs_we;
  logic [FRAME_BITS-1:0] fs_waddr, fs_raddr;
  logic [1:0]            fs_wdata, fs_rdata;

  cpcd_ram #(.WIDTH(SLOT_WIDTH), .DEPTH(SLOTS)) u_slot (
    .clk(clk), .we(sl_we), .waddr(sl_waddr), .wdata(sl_wdata),
    .raddr(sl_raddr), .rdata(sl_rdata));
  cpcd_ram #(.WIDTH(PAGE_BITS), .DEPTH(FRAMES)) u_fpage (
    .clk(clk), .we(fp_we), .waddr(fp_waddr), .wdata(fp_wdata),
    .raddr(fp_raddr), .rdata(fp_rdata));
  cpcd_ram #(.WIDTH(FRAME_BITS), .DEPTH(FRAMES)) u_stack (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata));
  cpcd_ram #(.WIDTH(2), .DEPTH(FRAMES)) u_fstat (
    .clk(clk), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
    .raddr(fs_raddr), .rdata(fs_rdata));

  assign sd_page  = sl_rdata[PAGE_BITS-1:0];
  assign sd_frame = sl_rdata[SLOT_WIDTH-1:PAGE_BITS];
  assign sd_home  = home_of(sd_page);
  assign stays    = (hole <= j) ? (sd_home > hole && sd_home <= j)
                                : (sd_home > hole || sd_home <= j);
  assign depth_m1 = depth - DEPTH_BITS'(1);
  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state; s_next = s; cnt_next = cnt; hole_next = hole; j_next = j;
    n_next = n; outer_next = outer; clr_next = clr; tgt_next = tgt; pid_next = pid;
    op_next = op; ev_next = ev; stk_wr_next = stk_wr; vvalid_next = vvalid;
    fsel_next = fsel; hand_next = hand; depth_next = depth; lowmark_next = lowmark;
    swn_next = swn; res_rej_next = res_rej; res_hit_next = res_hit; res_ev_next = res_ev;
    res_frame_next = res_frame; res_evp_next = res_evp;
    fs_we = 1'b0; fs_waddr = fsel; fs_wdata = 2'b00; fs_raddr = hand;
    sl_we = 1'b0; sl_waddr = hole; sl_wdata = '0; sl_raddr = s;
    fp_we = 1'b0; fp_waddr = fsel; fp_wdata = pid; fp_raddr = hand;
    st_we = 1'b0; st_waddr = depth[FRAME_BITS-1:0]; st_wdata = fsel;
    st_raddr = depth_m1[FRAME_BITS-1:0];
    load = 1'b0;
    case (state)
      ST_CLR: begin
        sl_we = 1'b1; sl_waddr = clr; sl_wdata = '0;
        fs_we = 1'b1; fs_waddr = clr[FRAME_BITS-1:0]; fs_wdata = 2'b00;
        clr_next = clr + SLOT_BITS'(1);
        if (clr == SLOT_BITS'(SLOTS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          op_next = s_tdata[1:0]; pid_next = s_tdata[65:2]; tgt_next = s_tdata[65:2];
          ev_next = 1'b0; cnt_next = '0;
          s_next = home_of(s_tdata[65:2]); sl_raddr = home_of(s_tdata[65:2]);
          res_rej_next = 1'b0; res_hit_next = 1'b0; res_ev_next = 1'b0;
          res_frame_next = '0; res_evp_next = '0;
          if (s_tdata[65:2] == '0) begin
            res_rej_next = 1'b1; state_next = ST_OUT;
          end else if (s_tdata[1:0] != FN_LOOKUP && s_tdata[1:0] != FN_INSERT &&
                       s_tdata[1:0] != FN_REMOVE) begin
            state_next = ST_OUT;
          end else begin
            state_next = ST_LOC;
          end
        end
      end
      ST_LOC: begin
        if (sd_page != '0 && sd_page == tgt) begin
          hole_next = s;
          if (ev) begin
            state_next = ST_ER;
          end else if (op == FN_REMOVE) begin
            fsel_next = sd_frame; state_next = ST_ER;
          end else begin
            // a mapped page always has a valid frame
            fs_we = 1'b1; fs_waddr = sd_frame; fs_wdata = 2'b11;
            res_hit_next = 1'b1; res_frame_next = sd_frame; state_next = ST_OUT;
          end
        end else if (sd_page == '0 || cnt == SLOT_BITS'(SLOTS - 1)) begin
          if (ev) begin
            state_next = ST_ALLOC;
          end else if (op == FN_INSERT) begin
            if (depth != '0) begin
              depth_next = depth_m1;
              stk_wr_next = (depth_m1 >= lowmark);
              if (depth_m1 < lowmark) lowmark_next = depth_m1;
              state_next = ST_POP;
            end else begin
              swn_next = '0; state_next = ST_SWEEP;
            end
          end else begin
            state_next = ST_OUT;
          end
        end else begin
          s_next = s + SLOT_BITS'(1); sl_raddr = s + SLOT_BITS'(1);
          cnt_next = cnt + SLOT_BITS'(1);
        end
      end
      ST_POP: begin
        // entries below the lowest depth ever reached were never written; their frame is computed instead
        fsel_next = stk_wr ? st_rdata
                           : FRAME_BITS'(FRAMES - 1) - depth[FRAME_BITS-1:0];
        state_next = ST_ALLOC;
      end
      ST_SWEEP: begin
        // status of hand was read last cycle; fetch the next frame meanwhile
        hand_next = hand + FRAME_BITS'(1);
        swn_next = swn + SWEEP_BITS'(1);
        fs_raddr = hand + FRAME_BITS'(1);
        if ((fs_rdata[0] && !fs_rdata[1]) || swn == SWEEP_BITS'(2 * FRAMES)) begin
          fsel_next = hand; vvalid_next = fs_rdata[0]; fp_raddr = hand;
          state_next = ST_VRD;
        end else if (fs_rdata[0]) begin
          fs_we = 1'b1; fs_waddr = hand; fs_wdata = 2'b01;
        end
      end
      ST_VRD: begin
        res_ev_next = 1'b1;
        res_evp_next = vvalid ? fp_rdata : '0;
        tgt_next = vvalid ? fp_rdata : '0;
        ev_next = 1'b1; cnt_next = '0;
        s_next = home_of(vvalid ? fp_rdata : '0);
        sl_raddr = home_of(vvalid ? fp_rdata : '0);
        state_next = ST_LOC;
      end
      ST_ER: begin
        sl_we = 1'b1; sl_waddr = hole; sl_wdata = '0;
        j_next = hole + SLOT_BITS'(1); sl_raddr = hole + SLOT_BITS'(1);
        n_next = '0; state_next = ST_ERC;
      end
      ST_ERC: begin
        if (sd_page == '0) begin
          state_next = ev ? ST_ALLOC : ST_OUT;
        end else if (stays) begin
          if (n == SLOT_BITS'(SLOTS - 1)) begin
            state_next = ev ? ST_ALLOC : ST_OUT;
          end else begin
            n_next = n + SLOT_BITS'(1);
            j_next = j + SLOT_BITS'(1); sl_raddr = j + SLOT_BITS'(1);
          end
        end else begin
          sl_we = 1'b1; sl_waddr = hole; sl_wdata = sl_rdata;
          hole_next = j; outer_next = outer + SLOT_BITS'(1);
          if (outer == SLOT_BITS'(SLOTS - 1)) state_next = ev ? ST_ALLOC : ST_OUT;
          else state_next = ST_ER;
        end
        if (state_next == ST_OUT) begin
          // remove finished: free the frame
          fs_we = 1'b1; fs_wdata = 2'b00;
          res_hit_next = 1'b1; res_frame_next = fsel;
          if (depth < DEPTH_BITS'(FRAMES)) begin
            st_we = 1'b1; depth_next = depth + DEPTH_BITS'(1);
          end
        end
      end
      ST_ALLOC: begin
        fp_we = 1'b1;
        fs_we = 1'b1; fs_wdata = 2'b01;
        res_frame_next = fsel; ev_next = 1'b0; cnt_next = '0;
        s_next = home_of(pid); sl_raddr = home_of(pid);
        state_next = ST_PLC;
      end
      ST_PLC: begin
        if (sd_page == '0) begin
          sl_we = 1'b1; sl_waddr = s; sl_wdata = {fsel, pid};
          state_next = ST_OUT;
        end else if (cnt == SLOT_BITS'(SLOTS - 1)) begin
          state_next = ST_OUT;
        end else begin
          s_next = s + SLOT_BITS'(1); sl_raddr = s + SLOT_BITS'(1);
          cnt_next = cnt + SLOT_BITS'(1);
        end
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          load = 1'b1; state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    if (state_next == ST_ER && state != ST_ERC) outer_next = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR; clr <= '0; depth <= DEPTH_BITS'(FRAMES);
      lowmark <= DEPTH_BITS'(FRAMES); hand <= '0; m_tvalid <= 1'b0;
    end else begin
      state <= state_next; clr <= clr_next; depth <= depth_next;
      lowmark <= lowmark_next; hand <= hand_next;
      m_tvalid <= load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid);
    end
  end

  always_ff @(posedge clk) begin
    s <= s_next; cnt <= cnt_next; hole <= hole_next; j <= j_next; n <= n_next;
    outer <= outer_next; tgt <= tgt_next; pid <= pid_next; op <= op_next; ev <= ev_next;
    stk_wr <= stk_wr_next; vvalid <= vvalid_next; fsel <= fsel_next; swn <= swn_next;
    res_rej <= res_rej_next; res_hit <= res_hit_next; res_ev <= res_ev_next;
    res_frame <= res_frame_next; res_evp <= res_evp_next;
    if (load) m_tdata <= {5'd0, res_evp, res_ev, res_frame, res_hit, res_rej};
  end

`ifndef ASSERT_OFF
  a_depth_range: assert property (@(posedge clk) disable iff (rst)
    depth <= DEPTH_BITS'(FRAMES) && lowmark <= depth)
    else $error("free stack depth out of range");
  a_sweep_full: assert property (@(posedge clk) disable iff (rst)
    state == ST_SWEEP |-> depth == '0)
    else $error("CLOCK sweep with free frames left");
  a_rej_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[74:1] == '0)
    else $error("rejected result carries data");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state != ST_IDLE)
    else $error("request transfer did not start work");
`endif
endmodule
